@@ sv/mss_pkg.sv @@
// Shared types, constants and decode helpers for the segment scanner.
// No dependencies; imported by all scanner modules.
package mss_pkg;

	localparam int unsigned LangW   = 6;
	localparam int unsigned ByteW   = 8;
	localparam int unsigned CountW  = 8;
	localparam int unsigned SkipW   = 3;
	localparam int unsigned AddrW   = 3;
	localparam int unsigned DataW   = 32;

	localparam logic [AddrW-1:0] RegSelLang = 3'd0;

	// reserved codes 29, 32, 35, 46
	localparam logic [63:0] ReservedCodes = (64'd1 << 29) | (64'd1 << 32) |
		(64'd1 << 35) | (64'd1 << 46);

	localparam logic [ByteW-1:0] MarkMask = 8'hC0;
	localparam logic [ByteW-1:0] MarkCode = 8'h80;

	localparam logic [CountW-1:0] CountMax = 8'hFF;

	typedef struct packed {
		logic             is_marker;
		logic [LangW-1:0] segment_language;
		logic             selected_text;
		logic [CountW-1:0] segment_total;
		logic             selected_found;
		logic             is_last;
	} mss_res_t;

	function automatic logic lang_supported(input logic [LangW-1:0] code);
		return ~ReservedCodes[code];
	endfunction

	// remaining bytes to skip after a text lead byte
	function automatic logic [SkipW-1:0] lead_skip(input logic [ByteW-1:0] b);
		logic [SkipW-1:0] r;
		r = 3'd1;
		if (!b[7])                       r = 3'd0;
		else if ((b & 8'hFE) == 8'hFE)   r = 3'd6;
		else if ((b & 8'hFC) == 8'hFC)   r = 3'd5;
		else if ((b & 8'hF8) == 8'hF8)   r = 3'd4;
		else if ((b & 8'hF0) == 8'hF0)   r = 3'd3;
		else if ((b & 8'hE0) == 8'hE0)   r = 3'd2;
		return r;
	endfunction

endpackage

@@ sv/mss_regs.sv @@
// APB-style configuration register file: selected language.
// Depends on mss_pkg.
module mss_regs (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic [mss_pkg::AddrW-1:0] paddr,
	input  logic [mss_pkg::DataW-1:0] pwdata,
	output logic [mss_pkg::DataW-1:0] prdata,
	output logic                      pready,
	output logic [mss_pkg::LangW-1:0] sel_lang
);
	import mss_pkg::*;

	logic [LangW-1:0] sel_q;
	logic             wr_en;
	logic             hit;

	assign pready = 1'b1;
	assign hit    = (paddr[AddrW-1:2] == RegSelLang[AddrW-1:2]);
	assign wr_en  = psel && penable && pwrite && hit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sel_q <= '0;
		end else if (wr_en) begin
			sel_q <= pwdata[LangW-1:0];
		end
	end

	assign prdata   = hit ? {{(DataW-LangW){1'b0}}, sel_q} : '0;
	assign sel_lang = sel_q;

endmodule

@@ sv/mss_scan.sv @@
// Per-byte scan state (skip count, language, segment count, found) and
// the combinational result for the byte on the input. Depends on mss_pkg.
module mss_scan (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      advance,
	input  logic [mss_pkg::ByteW-1:0] byte_value,
	input  logic                      buffer_start,
	input  logic                      buffer_end,
	input  logic [mss_pkg::LangW-1:0] sel_lang,
	output mss_pkg::mss_res_t         res
);
	import mss_pkg::*;

	logic [SkipW-1:0]  skip_q, skip_d;
	logic [LangW-1:0]  lang_q, lang_d;
	logic [CountW-1:0] count_q, count_d, count_base;
	logic              found_q, found_d, found_base;
	logic              marker;
	logic              sel_ok;

	assign sel_ok = lang_supported(sel_lang);

	always_comb begin
		marker     = 1'b0;
		skip_d     = skip_q;
		lang_d     = lang_q;
		count_base = count_q;
		found_base = found_q;
		if (buffer_start) begin
			marker     = 1'b1;
			skip_d     = '0;
			count_base = '0;
			found_base = 1'b0;
		end else if (skip_q != '0) begin
			skip_d = skip_q - 1'b1;
		end else if ((byte_value & MarkMask) == MarkCode) begin
			marker = 1'b1;
		end else begin
			skip_d = lead_skip(byte_value);
		end

		count_d = count_base;
		found_d = found_base;
		if (marker) begin
			lang_d = byte_value[LangW-1:0];
			if (count_base != CountMax) count_d = count_base + 1'b1;
			if (lang_d == sel_lang && sel_ok) found_d = 1'b1;
		end

		res.is_marker        = marker;
		res.segment_language = lang_d;
		res.selected_text    = !marker && (lang_d == sel_lang) && sel_ok;
		res.segment_total    = count_d;
		res.selected_found   = found_d;
		res.is_last          = buffer_end;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skip_q  <= '0;
			lang_q  <= '0;
			count_q <= '0;
			found_q <= 1'b0;
		end else if (advance) begin
			skip_q  <= skip_d;
			lang_q  <= lang_d;
			count_q <= count_d;
			found_q <= found_d;
		end
	end

endmodule

@@ sv/multilang_segment_scanner_core.sv @@
// Segment scanner top: config registers, scan logic and result register.
// Takes one byte per cycle unless a held result stalls the input (in_stall);
// the scan state update and decode sit between the input and the result
// register. Reset clears scan state, the selected language and the result
// valid. Depends on mss_pkg, mss_regs, mss_scan.
module multilang_segment_scanner_core (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic [mss_pkg::AddrW-1:0] paddr,
	input  logic [mss_pkg::DataW-1:0] pwdata,
	output logic [mss_pkg::DataW-1:0] prdata,
	output logic                      pready,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic [mss_pkg::ByteW-1:0] byte_value,
	input  logic                      buffer_start,
	input  logic                      buffer_end,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic                      is_marker,
	output logic [mss_pkg::LangW-1:0] segment_language,
	output logic                      selected_text,
	output logic [mss_pkg::CountW-1:0] segment_total,
	output logic                      selected_found,
	output logic                      is_last
);
	import mss_pkg::*;

	logic [LangW-1:0] sel_lang;
	logic             advance;
	mss_res_t         res;
	mss_res_t         res_q;
	logic             valid_q;

	mss_regs u_regs (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.sel_lang (sel_lang)
	);

	assign in_stall = valid_q && out_stall;
	assign advance  = in_valid && !in_stall;

	mss_scan u_scan (
		.clk          (clk),
		.arst_n       (arst_n),
		.advance      (advance),
		.byte_value   (byte_value),
		.buffer_start (buffer_start),
		.buffer_end   (buffer_end),
		.sel_lang     (sel_lang),
		.res          (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (!in_stall) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res;
		end
	end

	assign out_valid        = valid_q;
	assign is_marker        = res_q.is_marker;
	assign segment_language = res_q.segment_language;
	assign selected_text    = res_q.selected_text;
	assign segment_total    = res_q.segment_total;
	assign selected_found   = res_q.selected_found;
	assign is_last          = res_q.is_last;

endmodule

@@ bench/multilang_segment_scanner_checker.sv @@
`timescale 1ns / 1ps
// Result checker for the segment scanner: follows register writes and byte beats,
// predicts each result beat and compares it field by field. Depends on mss_pkg.
module multilang_segment_scanner_checker (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic                       pready,
	input  logic [mss_pkg::AddrW-1:0]  paddr,
	input  logic [mss_pkg::DataW-1:0]  pwdata,
	input  logic                       in_valid,
	input  logic                       in_stall,
	input  logic [mss_pkg::ByteW-1:0]  byte_value,
	input  logic                       buffer_start,
	input  logic                       buffer_end,
	input  logic                       out_valid,
	input  logic                       out_stall,
	input  logic                       is_marker,
	input  logic [mss_pkg::LangW-1:0]  segment_language,
	input  logic                       selected_text,
	input  logic [mss_pkg::CountW-1:0] segment_total,
	input  logic                       selected_found,
	input  logic                       is_last,
	output int                         fail_count,
	output int                         pending
);
	import mss_pkg::*;

	mss_res_t          scan_results_q[$];
	logic [LangW-1:0]  watch_lang;
	logic [LangW-1:0]  cur_lang;
	logic [SkipW-1:0]  skip_left;
	logic [CountW-1:0] marker_count;
	logic              lang_seen;

	task automatic flag_error(input string msg);
		$display("ERROR @%0t: %s", $time, msg);
		fail_count++;
	endtask

	task automatic check_field(input string name, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			flag_error($sformatf("%s expected %0d got %0d", name, want, got));
		end
	endtask

	// total length of a text sequence led by b
	function automatic int unsigned seq_length(input logic [ByteW-1:0] b);
		casez (b)
			8'b0???????: return 1;
			8'b1111111?: return 7;
			8'b1111110?: return 6;
			8'b111110??: return 5;
			8'b11110???: return 4;
			8'b1110????: return 3;
			default:     return 2;
		endcase
	endfunction

	function automatic mss_res_t scan_byte(input logic [ByteW-1:0] b, input logic s,
			input logic e);
		mss_res_t r;
		logic     marker;
		logic     wanted;
		marker = 1'b0;
		if (s || (skip_left == '0 && b[7:6] == 2'b10)) begin
			marker = 1'b1;
			if (s) begin
				marker_count = '0;
				lang_seen = 1'b0;
				skip_left = '0;
			end
			cur_lang = b[LangW-1:0];
			if (marker_count != CountMax) marker_count++;
			if (cur_lang == watch_lang && !ReservedCodes[watch_lang]) lang_seen = 1'b1;
		end else if (skip_left != '0) begin
			skip_left--;
		end else begin
			skip_left = SkipW'(seq_length(b) - 1);
		end
		wanted = cur_lang == watch_lang && !ReservedCodes[watch_lang];
		r.is_marker = marker;
		r.segment_language = cur_lang;
		r.selected_text = !marker && wanted;
		r.segment_total = marker_count;
		r.selected_found = lang_seen;
		r.is_last = e;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		mss_res_t want;
		if (!arst_n) begin
			scan_results_q.delete();
			watch_lang = '0;
			cur_lang = '0;
			skip_left = '0;
			marker_count = '0;
			lang_seen = 1'b0;
			fail_count = 0;
			pending = 0;
		end else begin
			if (psel && penable && pwrite && pready &&
					paddr[AddrW-1:2] == RegSelLang[AddrW-1:2]) begin
				watch_lang = pwdata[LangW-1:0];
			end
			if (out_valid && !out_stall) begin
				if (scan_results_q.size() == 0) begin
					flag_error("result beat with nothing expected");
				end else begin
					want = scan_results_q.pop_front();
					check_field("is_marker", want.is_marker, is_marker);
					check_field("segment_language", want.segment_language, segment_language);
					check_field("selected_text", want.selected_text, selected_text);
					check_field("segment_total", want.segment_total, segment_total);
					check_field("selected_found", want.selected_found, selected_found);
					check_field("is_last", want.is_last, is_last);
				end
			end
			if (in_valid && !in_stall) begin
				scan_results_q.insert(scan_results_q.size(),
					scan_byte(byte_value, buffer_start, buffer_end));
			end
			pending = scan_results_q.size();
		end
	end

endmodule

@@ bench/multilang_segment_scanner_core_test.sv @@
`timescale 1ns / 1ps
// Top of the segment scanner bench: clock, reset, register writes, byte beats,
// result stalls and the verdict. Depends on mss_pkg, the core and the checker.
module multilang_segment_scanner_core_test;
	import mss_pkg::*;

	localparam int HoldCycles  = 60;
	localparam int QuietLimit  = 2000;
	localparam int PhaseItems  = 55;
	localparam int SatMarkers  = 260;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [AddrW-1:0]  paddr;
	logic [DataW-1:0]  pwdata;
	logic [DataW-1:0]  prdata;
	logic              pready;
	logic              in_valid;
	logic              in_stall;
	logic [ByteW-1:0]  byte_value;
	logic              buffer_start;
	logic              buffer_end;
	logic              out_valid;
	logic              out_stall;
	logic              is_marker;
	logic [LangW-1:0]  segment_language;
	logic              selected_text;
	logic [CountW-1:0] segment_total;
	logic              selected_found;
	logic              is_last;
	int                fail_count;
	int                pending;

	logic              calm = 1'b0;
	logic              hold_req = 1'b0;
	logic [LangW-1:0]  cur_sel;
	int                gen_left = 0;
	int                gen_cont = 0;
	int                quiet_cycles = 0;
	logic [LangW-1:0]  lang_plan [8] = '{6'd0, 6'd63, 6'd29, 6'd12, 6'd46, 6'd0, 6'd32,
		6'd35};

	multilang_segment_scanner_core uut (
		.clk, .arst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
		.in_valid, .in_stall, .byte_value, .buffer_start, .buffer_end,
		.out_valid, .out_stall, .is_marker, .segment_language, .selected_text,
		.segment_total, .selected_found, .is_last
	);

	multilang_segment_scanner_checker u_check (
		.clk, .arst_n, .psel, .penable, .pwrite, .pready, .paddr, .pwdata,
		.in_valid, .in_stall, .byte_value, .buffer_start, .buffer_end,
		.out_valid, .out_stall, .is_marker, .segment_language, .selected_text,
		.segment_total, .selected_found, .is_last, .fail_count, .pending
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
		else quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QuietLimit) begin
			$display("status: fail");
			$finish;
		end
	end

	// result side: random stall bursts, one long hold on request
	initial begin
		out_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_req) begin
				out_stall <= 1'b1;
				repeat (HoldCycles) @(posedge clk);
				out_stall <= 1'b0;
				hold_req = 1'b0;
			end else if (!calm && $urandom_range(0, 5) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 8)) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	task automatic write_sel(input logic [LangW-1:0] v);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= RegSelLang;
		pwdata <= DataW'(v);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic send_byte(input logic [ByteW-1:0] b, input logic s, input logic e);
		int gap;
		if (!calm && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 8);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		byte_value <= b;
		buffer_start <= s;
		buffer_end <= e;
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	task automatic wait_drained;
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	function automatic logic [LangW-1:0] pick_code();
		logic [LangW-1:0] code;
		case ($urandom_range(0, 3))
			0: code = cur_sel;
			1: begin
				do code = LangW'($urandom); while (!ReservedCodes[code]);
			end
			default: code = LangW'($urandom);
		endcase
		return code;
	endfunction

	function automatic logic [ByteW-1:0] lead_byte(input int len);
		case (len)
			1:       return {1'b0, 7'($urandom)};
			2:       return {3'b110, 5'($urandom)};
			3:       return {4'b1110, 4'($urandom)};
			4:       return {5'b11110, 3'($urandom)};
			5:       return {6'b111110, 2'($urandom)};
			6:       return {7'b1111110, 1'($urandom)};
			default: return {7'b1111111, 1'($urandom)};
		endcase
	endfunction

	// mostly well-formed buffers, some noise and missing start/end flags
	task automatic next_random_item;
		logic [ByteW-1:0] b;
		logic             s;
		logic             e;
		int               len;
		if ($urandom_range(0, 11) == 0) begin
			send_byte(8'($urandom), $urandom_range(0, 7) == 0, $urandom_range(0, 5) == 0);
			return;
		end
		s = 1'b0;
		if (gen_left == 0) begin
			gen_left = $urandom_range(3, 40);
			gen_cont = 0;
			s = $urandom_range(0, 7) != 0;
			b = ($urandom_range(0, 3) == 0) ? 8'($urandom) : {2'b10, pick_code()};
		end else if (gen_cont != 0) begin
			b = 8'($urandom);
			gen_cont--;
		end else if ($urandom_range(0, 3) == 0) begin
			b = {2'b10, pick_code()};
		end else begin
			len = $urandom_range(0, 1) ? $urandom_range(1, 3) : $urandom_range(1, 7);
			b = lead_byte(len);
			gen_cont = len - 1;
		end
		gen_left--;
		e = (gen_left == 0) ? ($urandom_range(0, 7) != 0) : ($urandom_range(0, 31) == 0);
		send_byte(b, s, e);
	endtask

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_valid = 1'b0;
		byte_value = '0;
		buffer_start = 1'b0;
		buffer_end = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		cur_sel = 6'd63;
		write_sel(cur_sel);

		// bytes ahead of any start, skip cut by a new start
		send_byte(8'h41, 1'b0, 1'b0);
		send_byte(8'h85, 1'b0, 1'b0);
		send_byte(8'hC3, 1'b0, 1'b1);
		send_byte(8'hBF, 1'b1, 1'b0);
		send_byte(8'h00, 1'b0, 1'b0);
		send_byte(8'h7F, 1'b0, 1'b0);
		// longest lead: marker-like bytes inside the skip stay text
		send_byte(8'hFF, 1'b0, 1'b0);
		send_byte(8'h80, 1'b0, 1'b0);
		send_byte(8'hBF, 1'b0, 1'b0);
		send_byte(8'hFE, 1'b0, 1'b0);
		send_byte(8'h00, 1'b0, 1'b0);
		send_byte(8'hFF, 1'b0, 1'b0);
		send_byte(8'hC0, 1'b0, 1'b0);
		// reserved language segment
		send_byte(8'h9D, 1'b0, 1'b0);
		send_byte(8'h41, 1'b0, 1'b0);
		send_byte(8'hE0, 1'b0, 1'b0);
		send_byte(8'h12, 1'b0, 1'b0);
		send_byte(8'h34, 1'b0, 1'b0);
		send_byte(8'hA0, 1'b0, 1'b1);

		for (int ph = 0; ph < 8; ph++) begin
			wait_drained;
			cur_sel = (ph == 5) ? LangW'($urandom) : lang_plan[ph];
			write_sel(cur_sel);
			if (ph == 7) calm = 1'b1;
			if (ph == 2) hold_req = 1'b1;
			for (int n = 0; n < PhaseItems; n++) begin
				if (ph == 4 && n == PhaseItems / 2) wait_drained;
				next_random_item();
			end
			// one long buffer of markers to saturate the segment count
			if (ph == 3) begin
				for (int k = 0; k < SatMarkers; k++) begin
					send_byte({2'b10, pick_code()}, k == 0, k == SatMarkers - 1);
				end
				gen_left = 0;
			end
		end

		wait_drained;
		repeat (8) @(posedge clk);
		if (fail_count == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
